### sv/diff_drive_wheel_command_macros.svh
// Assertion macros shared by the wheel command RTL.
`ifndef DIFF_DRIVE_WHEEL_COMMAND_MACROS_SVH
`define DIFF_DRIVE_WHEEL_COMMAND_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DDWC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DDWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/ddwc_pkg.sv
// Package with shared types and constants of the wheel command block.
`default_nettype none
package ddwc_pkg;

    typedef enum logic [1:0] {
        CFG_TURN_GAIN  = 2'd0,
        CFG_MIN_LIN    = 2'd1,
        CFG_MIN_TURN   = 2'd2,
        CFG_INV_RADIUS = 2'd3
    } t_cfg_idx;

    localparam int unsigned NumW  = 31;
    localparam int unsigned DenW  = 15;
    localparam int unsigned SideW = 40;

    localparam logic [15:0] TurnGainRst  = 16'd410;
    localparam logic [14:0] MinLinRst    = 15'd205;
    localparam logic [14:0] MinTurnRst   = 15'd205;
    localparam logic [15:0] InvRadiusRst = 16'd7314;

    localparam logic [20:0] NoiseFloor = 21'd4;

    localparam logic signed [30:0] OutMax = 31'sd8388607;
    localparam logic signed [30:0] OutMin = -31'sd8388608;

endpackage
`default_nettype wire

### sv/ddwc_div.sv
// Pipelined two-lane restoring divider, one quotient bit per stage.
`default_nettype none
module ddwc_div #(
    parameter int unsigned NW = 31,
    parameter int unsigned DW = 15,
    parameter int unsigned SW = 40
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic [NW-1:0]      i_num_a,
    input  wire logic [DW-1:0]      i_den_a,
    input  wire logic [NW-1:0]      i_num_b,
    input  wire logic [DW-1:0]      i_den_b,
    input  wire logic [SW-1:0]      i_side,
    output logic                    o_valid,
    output logic [NW-1:0]           o_quo_a,
    output logic [NW-1:0]           o_quo_b,
    output logic [SW-1:0]           o_side
);

    logic                      r_vld  [NW+1];
    logic [1:0][NW-1:0]        r_num  [NW+1];
    logic [1:0][NW-1:0]        r_quo  [NW+1];
    logic [1:0][DW-1:0]        r_den  [NW+1];
    logic [1:0][DW-1:0]        r_rem  [NW+1];
    logic [SW-1:0]             r_side [NW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0]  <= {i_num_b, i_num_a};
            r_den[0]  <= {i_den_b, i_den_a};
            r_quo[0]  <= '0;
            r_rem[0]  <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [1:0][DW:0]   trial;
        logic [1:0][DW:0]   diff;
        logic [1:0][DW-1:0] n_rem;
        logic [1:0][NW-1:0] n_quo;

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                trial[l] = {r_rem[k][l], r_num[k][l][NW-1-k]};
                diff[l]  = trial[l] - {1'b0, r_den[k][l]};
                if (trial[l] >= {1'b0, r_den[k][l]}) begin
                    n_rem[l] = diff[l][DW-1:0];
                    n_quo[l] = {r_quo[k][l][NW-2:0], 1'b1};
                end else begin
                    n_rem[l] = trial[l][DW-1:0];
                    n_quo[l] = {r_quo[k][l][NW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k+1]  <= r_num[k];
                r_den[k+1]  <= r_den[k];
                r_quo[k+1]  <= n_quo;
                r_rem[k+1]  <= n_rem;
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_vld[NW];
    assign o_quo_a = r_quo[NW][0];
    assign o_quo_b = r_quo[NW][1];
    assign o_side  = r_side[NW];

endmodule
`default_nettype wire

### sv/diff_drive_wheel_command.sv
// Top level of the differential-drive wheel command pipeline.
`default_nettype none
`include "diff_drive_wheel_command_macros.svh"
// Turns a linear and angular velocity command (signed Q4.12) into left and right
// wheel rates (signed Q12.12, saturated). The block takes one transfer per clock
// while the output is not stalled. An item passes 41 register stages: three front
// stages, the 32-stage pipelined divider (an input register plus 31 quotient-bit
// stages) that forms the low-speed boost, five boost, multiply and sum stages, and
// the output register. The first stage loads at the accepting edge. A stall on the
// output side freezes the whole pipeline, so nothing is lost or repeated. The user
// must write registers through the plain write port only while no command is in
// flight; the block itself does not enforce this.
module diff_drive_wheel_command (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [15:0] linear_velocity, [31:16] angular_velocity
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [47:0]      o_m_tdata,   // [23:0] left_wheel_rate, [47:24] right_wheel_rate
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_wdata
);

    logic en;

    logic [15:0] r_turn_gain;
    logic [14:0] r_min_lin;
    logic [14:0] r_min_turn;
    logic [15:0] r_inv_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_gain  <= ddwc_pkg::TurnGainRst;
            r_min_lin    <= ddwc_pkg::MinLinRst;
            r_min_turn   <= ddwc_pkg::MinTurnRst;
            r_inv_radius <= ddwc_pkg::InvRadiusRst;
        end else if (i_cfg_we) begin
            unique case (ddwc_pkg::t_cfg_idx'(i_cfg_index))
                ddwc_pkg::CFG_TURN_GAIN:  r_turn_gain  <= i_cfg_wdata;
                ddwc_pkg::CFG_MIN_LIN:    r_min_lin    <= i_cfg_wdata[14:0];
                ddwc_pkg::CFG_MIN_TURN:   r_min_turn   <= i_cfg_wdata[14:0];
                ddwc_pkg::CFG_INV_RADIUS: r_inv_radius <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic r_out_valid;
    assign en         = !r_out_valid || i_m_tready;
    assign o_s_tready = en;

    // Stage 1: turn product.
    logic               r1_valid;
    logic signed [15:0] r1_lin;
    logic signed [32:0] r1_prod;

    // Stage 2: turn part, truncated toward zero.
    logic               r2_valid;
    logic signed [15:0] r2_lin;
    logic signed [20:0] r2_turn;
    logic signed [32:0] n2_bias;

    // Stage 3: magnitudes and boost decision.
    logic               r3_valid;
    logic signed [15:0] r3_lin;
    logic signed [20:0] r3_turn;
    logic               r3_boost;
    logic [14:0]        r3_alin;
    logic [14:0]        r3_aturn;
    logic signed [16:0] n3_lin_x;
    logic [16:0]        n3_alin;
    logic [20:0]        n3_aturn;
    logic               n3_boost;

    always_comb begin
        n2_bias  = r1_prod + (r1_prod[32] ? 33'sd4095 : 33'sd0);
        n3_lin_x = {r2_lin[15], r2_lin};
        n3_alin  = n3_lin_x[16] ? 17'(-n3_lin_x) : 17'(n3_lin_x);
        n3_aturn = r2_turn[20] ? 21'(-r2_turn) : 21'(r2_turn);
        n3_boost = (n3_alin < {2'b0, r_min_lin}) && (n3_aturn < {6'b0, r_min_turn})
                && ((n3_alin > ddwc_pkg::NoiseFloor[16:0])
                    || (n3_aturn > ddwc_pkg::NoiseFloor));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_s_tvalid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_lin   <= $signed(i_s_tdata[15:0]);
            r1_prod  <= $signed(i_s_tdata[31:16]) * $signed({1'b0, r_turn_gain});
            r2_lin   <= r1_lin;
            r2_turn  <= n2_bias[32:12];
            r3_lin   <= r2_lin;
            r3_turn  <= r2_turn;
            r3_boost <= n3_boost;
            r3_alin  <= n3_alin[14:0];
            r3_aturn <= n3_aturn[14:0];
        end
    end

    // Both scales come out of the shared divider pipeline with the item's data.
    logic                           div_valid;
    logic [ddwc_pkg::NumW-1:0]      quo_lin;
    logic [ddwc_pkg::NumW-1:0]      quo_turn;
    logic [ddwc_pkg::SideW-1:0]     div_side;
    logic [ddwc_pkg::SideW-1:0]     side_in;

    assign side_in = {r3_boost, (r3_alin == '0), (r3_aturn == '0), r3_turn, r3_lin};

    ddwc_div #(
        .NW(ddwc_pkg::NumW),
        .DW(ddwc_pkg::DenW),
        .SW(ddwc_pkg::SideW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_valid),
        .i_num_a ({r_min_lin, 16'b0}),
        .i_den_a (r3_alin),
        .i_num_b ({r_min_turn, 16'b0}),
        .i_den_b (r3_aturn),
        .i_side  (side_in),
        .o_valid (div_valid),
        .o_quo_a (quo_lin),
        .o_quo_b (quo_turn),
        .o_side  (div_side)
    );

    // Stage 4: common boost factor.
    logic               n4_lz, n4_tz;
    logic [30:0]        n4_ls, n4_ts, n4_s;
    logic               r4_valid;
    logic [30:0]        r4_s;
    logic signed [15:0] r4_lin;
    logic signed [20:0] r4_turn;
    logic               r4_boost;

    always_comb begin
        n4_lz = div_side[38];
        n4_tz = div_side[37];
        n4_ls = n4_lz ? '0 : quo_lin;
        n4_ts = n4_tz ? '0 : quo_turn;
        if (!n4_lz && !n4_tz) begin
            n4_s = (n4_ls < n4_ts) ? n4_ls : n4_ts;
        end else begin
            n4_s = (n4_ls > n4_ts) ? n4_ls : n4_ts;
        end
    end

    // Stage 5: boosted products. Stage 6: rescale and select.
    logic               r5_valid;
    logic signed [47:0] r5_plin;
    logic signed [47:0] r5_pturn;
    logic signed [15:0] r5_lin;
    logic signed [20:0] r5_turn;
    logic               r5_boost;
    logic signed [47:0] n6_blin, n6_bturn;
    logic signed [15:0] n6_lin_b, n6_turn_b;
    logic signed [15:0] n6_lin_lim;
    logic               r6_valid;
    logic signed [15:0] r6_lb;
    logic signed [20:0] r6_tb;

    // Stage 7: wheel sums. Stage 8: radius products.
    logic               r7_valid;
    logic signed [21:0] r7_dif, r7_sum;
    logic               r8_valid;
    logic signed [38:0] r8_wl, r8_wr;

    always_comb begin
        n6_blin    = r5_plin  + (r5_plin[47]  ? 48'sd65535 : 48'sd0);
        n6_bturn   = r5_pturn + (r5_pturn[47] ? 48'sd65535 : 48'sd0);
        n6_lin_b   = n6_blin[31:16];
        n6_turn_b  = n6_bturn[31:16];
        n6_lin_lim = $signed({1'b0, r_min_lin});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
            r8_valid <= 1'b0;
        end else if (en) begin
            r4_valid <= div_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
            r7_valid <= r6_valid;
            r8_valid <= r7_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_s     <= n4_s;
            r4_lin   <= $signed(div_side[15:0]);
            r4_turn  <= $signed(div_side[36:16]);
            r4_boost <= div_side[39];
            r5_plin  <= r4_lin * $signed({1'b0, r4_s});
            // In the boost case the turn part is below 2^15 in magnitude.
            r5_pturn <= $signed(r4_turn[15:0]) * $signed({1'b0, r4_s});
            r5_lin   <= r4_lin;
            r5_turn  <= r4_turn;
            r5_boost <= r4_boost;
            r6_lb    <= r5_boost ? n6_lin_b : r5_lin;
            r6_tb    <= r5_boost ? 21'(n6_turn_b) : r5_turn;
            r7_dif   <= 22'(r6_lb) - 22'(r6_tb);
            r7_sum   <= 22'(r6_lb) + 22'(r6_tb);
            r8_wl    <= r7_dif * $signed({1'b0, r_inv_radius});
            r8_wr    <= r7_sum * $signed({1'b0, r_inv_radius});
        end
    end

    // Output stage: truncate by 2^8 toward zero and saturate to 24 bits.
    logic signed [38:0] n9_bl, n9_br;
    logic signed [30:0] n9_ql, n9_qr;
    logic [23:0]        n9_left, n9_right;
    logic [23:0]        r_out_left, r_out_right;

    always_comb begin
        n9_bl = r8_wl + (r8_wl[38] ? 39'sd255 : 39'sd0);
        n9_br = r8_wr + (r8_wr[38] ? 39'sd255 : 39'sd0);
        n9_ql = n9_bl[38:8];
        n9_qr = n9_br[38:8];
        priority if (n9_ql > ddwc_pkg::OutMax) begin
            n9_left = ddwc_pkg::OutMax[23:0];
        end else if (n9_ql < ddwc_pkg::OutMin) begin
            n9_left = ddwc_pkg::OutMin[23:0];
        end else begin
            n9_left = n9_ql[23:0];
        end
        priority if (n9_qr > ddwc_pkg::OutMax) begin
            n9_right = ddwc_pkg::OutMax[23:0];
        end else if (n9_qr < ddwc_pkg::OutMin) begin
            n9_right = ddwc_pkg::OutMin[23:0];
        end else begin
            n9_right = n9_qr[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r8_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_left  <= n9_left;
            r_out_right <= n9_right;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_right, r_out_left};

    `DDWC_ASSERT_NEXT(a_out_follow, i_clk, i_rst_n, en && r8_valid, r_out_valid, "valid item lost at output stage")
    `DDWC_ASSERT_NOW(a_boost_scale, i_clk, i_rst_n, r4_valid && r4_boost, r4_s != '0, "boost selected with zero scale")
    `DDWC_ASSERT_NOW(a_boost_bound, i_clk, i_rst_n, r5_valid && r5_boost && en, (n6_lin_b <= n6_lin_lim) && (n6_lin_b >= -n6_lin_lim), "boosted linear speed exceeds its minimum")

endmodule
`default_nettype wire

### test/wheel_rate_checker.sv
// Checker that predicts wheel rates from accepted commands and compares results.
module wheel_rate_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] i_m_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    output int          o_errors,
    output int          o_pending
);

    logic [15:0] gain_q;
    logic [14:0] min_lin_q;
    logic [14:0] min_turn_q;
    logic [15:0] inv_rad_q;
    logic [47:0] wheel_rates_q[$];

    function automatic longint trunc_shift(longint v, int n);
        if (v < 0) return -((-v) >>> n);
        return v >>> n;
    endfunction

    function automatic logic [23:0] clamp24(longint v);
        if (v > 64'sd8388607) v = 64'sd8388607;
        if (v < -64'sd8388608) v = -64'sd8388608;
        return v[23:0];
    endfunction

    function automatic logic [47:0] wheel_rates(logic [31:0] cmd);
        longint lin, turn, alin, aturn, ls, ts, s, l, r;
        lin = longint'($signed(cmd[15:0]));
        turn = trunc_shift(longint'($signed(cmd[31:16])) * longint'(gain_q), 12);
        alin = lin < 0 ? -lin : lin;
        aturn = turn < 0 ? -turn : turn;
        if (alin < longint'(min_lin_q) && aturn < longint'(min_turn_q) &&
            (alin > 4 || aturn > 4)) begin
            ls = 0;
            ts = 0;
            if (alin > 0) ls = (longint'(min_lin_q) << 16) / alin;
            if (aturn > 0) ts = (longint'(min_turn_q) << 16) / aturn;
            if (ls != 0 && ts != 0) s = ls < ts ? ls : ts;
            else s = ls > ts ? ls : ts;
            lin = trunc_shift(lin * s, 16);
            turn = trunc_shift(turn * s, 16);
        end
        l = trunc_shift((lin - turn) * longint'(inv_rad_q), 8);
        r = trunc_shift((lin + turn) * longint'(inv_rad_q), 8);
        return {clamp24(r), clamp24(l)};
    endfunction

    always_ff @(posedge i_clk) begin
        logic [47:0] exp_rates;
        if (!i_rst_n) begin
            gain_q <= ddwc_pkg::TurnGainRst;
            min_lin_q <= ddwc_pkg::MinLinRst;
            min_turn_q <= ddwc_pkg::MinTurnRst;
            inv_rad_q <= ddwc_pkg::InvRadiusRst;
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                unique case (ddwc_pkg::t_cfg_idx'(i_cfg_index))
                    ddwc_pkg::CFG_TURN_GAIN:  gain_q <= i_cfg_wdata;
                    ddwc_pkg::CFG_MIN_LIN:    min_lin_q <= i_cfg_wdata[14:0];
                    ddwc_pkg::CFG_MIN_TURN:   min_turn_q <= i_cfg_wdata[14:0];
                    ddwc_pkg::CFG_INV_RADIUS: inv_rad_q <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) wheel_rates_q.push_back(wheel_rates(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (wheel_rates_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result %h", i_m_tdata);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_rates = wheel_rates_q.pop_front();
                    if (exp_rates !== i_m_tdata) begin
                        if (o_errors < 10)
                            $display("mismatch left exp %h got %h, right exp %h got %h",
                                exp_rates[23:0], i_m_tdata[23:0],
                                exp_rates[47:24], i_m_tdata[47:24]);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= wheel_rates_q.size();
        end
    end
endmodule

### test/testbench.sv
// Testbench top: drives commands and registers, stalls the output, gives the verdict.
module testbench;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;
    int          errors;
    int          pending;
    int          cycle_count = 0;
    bit          long_hold;

    diff_drive_wheel_command dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_wdata(cfg_wdata)
    );

    wheel_rate_checker checker_inst (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_wdata(cfg_wdata),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Small magnitudes are where the boost logic lives, so bias toward them.
    function automatic logic [15:0] rand_vel();
        case ($urandom_range(0, 3))
            0: return 16'($signed($urandom_range(0, 600)) - 300);
            1: return 16'($signed($urandom_range(0, 20)) - 10);
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: random stalls plus one long hold-off while the sender keeps going.
    initial begin
        int n;
        bit held;
        held = 0;
        m_tready = 0;
        @(posedge clk iff rst_n);
        forever begin
            if (long_hold && !held) begin
                m_tready <= 0;
                repeat (200) @(posedge clk);
                held = 1;
            end
            n = gap_len();
            if (n > 0) begin
                m_tready <= 0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // The caller drops the write enable after its last write.
    task automatic write_reg(ddwc_pkg::t_cfg_idx idx, logic [15:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic send_cmd(logic [15:0] lin, logic [15:0] ang);
        int n;
        n = gap_len();
        if (n > 0) begin
            s_tvalid <= 0;
            repeat (n) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {ang, lin};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    initial begin
        logic [15:0] edge_vals[10];
        long_hold = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = 0;
        cfg_we = 0;
        cfg_index = ddwc_pkg::CFG_TURN_GAIN;
        cfg_wdata = 0;
        edge_vals = '{16'h8000, 16'h7fff, 16'h0000, 16'h0004, 16'hfffc,
                      16'h0005, 16'hfffb, 16'h00cc, 16'hff34, 16'h0001};
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // Directed: extremes, noise floor edges, minimum edges, zero inputs.
        for (int i = 0; i < 5; i++)
            for (int j = 0; j < 5; j++)
                send_cmd(edge_vals[(i * 2) % 10], edge_vals[(j * 2 + i) % 10]);
        drain();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(ddwc_pkg::CFG_TURN_GAIN, 16'hffff);
                    write_reg(ddwc_pkg::CFG_MIN_LIN, 16'h7fff);
                    write_reg(ddwc_pkg::CFG_MIN_TURN, 16'h7fff);
                    write_reg(ddwc_pkg::CFG_INV_RADIUS, 16'hffff);
                end
                1: begin
                    write_reg(ddwc_pkg::CFG_TURN_GAIN, 16'h0000);
                    write_reg(ddwc_pkg::CFG_MIN_LIN, 16'h0000);
                    write_reg(ddwc_pkg::CFG_MIN_TURN, 16'h0000);
                    write_reg(ddwc_pkg::CFG_INV_RADIUS, 16'h0000);
                end
                2: begin
                    write_reg(ddwc_pkg::CFG_TURN_GAIN, 16'd410);
                    write_reg(ddwc_pkg::CFG_MIN_LIN, 16'd205);
                    write_reg(ddwc_pkg::CFG_MIN_TURN, 16'd205);
                    write_reg(ddwc_pkg::CFG_INV_RADIUS, 16'd7314);
                end
                default: begin
                    write_reg(ddwc_pkg::CFG_TURN_GAIN, 16'($urandom));
                    write_reg(ddwc_pkg::CFG_MIN_LIN, 16'($urandom));
                    write_reg(ddwc_pkg::CFG_MIN_TURN, 16'($urandom));
                    write_reg(ddwc_pkg::CFG_INV_RADIUS, 16'($urandom));
                end
            endcase
            cfg_we <= 0;
            if (phase == 3) long_hold = 1;
            for (int k = 0; k < 220; k++) send_cmd(rand_vel(), rand_vel());
            drain();
        end
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
